/* src/assert_macros.svh */
// Assertion macros shared by the page replacement RTL.
// No dependencies; taken in by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lpr_pkg.sv */
// Shared constants, types and controller/datapath structs for the LRU page
// replacement block. No dependencies.
package lpr_pkg;

    localparam int FRAMES       = 64;
    localparam int NUM_PAGES    = 8192;
    localparam int PAGE_BYTES   = 4096;
    localparam int FRAMES_RESET = 64;

    // Field widths of the request, result and register.
    localparam int ADDR_W    = 25;
    localparam int SIZE_W    = 4;
    localparam int CFG_W     = 7;
    localparam int PAGE_W    = 14;
    localparam int EVP_W     = 13;
    localparam int OUT_FRM_W = 6;
    localparam int CNT_W     = 40;

    // Internal widths derived from the sizing constants.
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W  = $clog2(FRAMES + 1);
    localparam int MAP_AW  = $clog2(NUM_PAGES);
    localparam int MAP_W   = FRAME_W + 1;
    localparam int OFF_W   = $clog2(PAGE_BYTES);

    typedef struct packed {
        logic clear;
        logic accept;
        logic next_page;
        logic fault;
        logic take_hit;
        logic fill;
        logic victim;
        logic evict;
        logic install;
        logic hit_upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic oor;
        logic hit;
        logic room;
        logic last;
        logic out_free;
    } sts_t;

endpackage

/* src/lpr_req_if.sv */
// Request channel: one memory access per request.
// Depends on lpr_pkg for the field widths.
interface lpr_req_if;
    logic                        valid;
    logic                        ready;
    logic [lpr_pkg::ADDR_W-1:0]  byte_address;
    logic [lpr_pkg::SIZE_W-1:0]  element_size;

    modport source (output valid, output byte_address, output element_size, input ready);
    modport sink   (input valid, input byte_address, input element_size, output ready);
endinterface

/* src/lpr_rsp_if.sv */
// Result channel: one result per page touched by an access.
// Depends on lpr_pkg for the field widths.
interface lpr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lpr_pkg::PAGE_W-1:0]    page_number;
    logic                          fault;
    logic                          evicted_valid;
    logic [lpr_pkg::EVP_W-1:0]     evicted_page;
    logic [lpr_pkg::OUT_FRM_W-1:0] frame_index;
    logic                          out_of_range;
    logic                          last_of_access;
    logic [lpr_pkg::CNT_W-1:0]     access_total;
    logic [lpr_pkg::CNT_W-1:0]     fault_total;

    modport source (
        output valid, output page_number, output fault, output evicted_valid,
        output evicted_page, output frame_index, output out_of_range,
        output last_of_access, output access_total, output fault_total,
        input ready
    );
    modport sink (
        input valid, input page_number, input fault, input evicted_valid,
        input evicted_page, input frame_index, input out_of_range,
        input last_of_access, input access_total, input fault_total,
        output ready
    );
endinterface

/* src/lpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    raddr_q;
    logic [WIDTH-1:0] rdata_reg;

    assign raddr_q = raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr_q];
    end

    assign rdata = rdata_reg;
endmodule

/* src/lpr_rank.sv */
// Recency ranks of the frames (0 is most recently used) with the in-place
// update, the rank lookup for a hit and the least recently used search. Uses lpr_pkg.
module lpr_rank (
    input  logic                          clk,
    input  logic                          upd,
    input  logic                          upd_all,
    input  logic [lpr_pkg::FRAME_W-1:0]   upd_sel,
    input  logic [lpr_pkg::FRAME_W-1:0]   upd_r,
    input  logic [lpr_pkg::FILL_W-1:0]    filled,
    input  logic [lpr_pkg::FRAME_W-1:0]   look_frame,
    output logic [lpr_pkg::FRAME_W-1:0]   look_rank,
    output logic [lpr_pkg::FRAME_W-1:0]   victim
);
    logic [lpr_pkg::FRAME_W-1:0] rank_reg [lpr_pkg::FRAMES];
    logic [lpr_pkg::FRAMES-1:0]  match_reg;
    logic [lpr_pkg::FRAMES-1:0]  match_next;
    logic [lpr_pkg::FRAME_W-1:0] look_rank_reg;
    logic [lpr_pkg::FRAME_W-1:0] look_rank_next;
    logic [lpr_pkg::FRAME_W-1:0] oldest;

    assign oldest = lpr_pkg::FRAME_W'(filled - 1'b1);

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            for (int i = 0; i < lpr_pkg::FRAMES; i++)
            begin
                if (lpr_pkg::FRAME_W'(i) == upd_sel)
                begin
                    rank_reg[i] <= '0;
                end
                else if (upd_all || (rank_reg[i] < upd_r))
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

    // The filled frames hold a permutation of ranks, so the oldest frame is
    // the only filled one whose rank is one less than the fill count.
    always_comb
    begin
        for (int i = 0; i < lpr_pkg::FRAMES; i++)
        begin
            match_next[i] = (lpr_pkg::FILL_W'(i) < filled) && (rank_reg[i] == oldest);
        end
    end

    always_comb
    begin
        look_rank_next = '0;
        for (int i = 0; i < lpr_pkg::FRAMES; i++)
        begin
            if (lpr_pkg::FRAME_W'(i) == look_frame)
            begin
                look_rank_next = look_rank_next | rank_reg[i];
            end
        end
    end

    always_comb
    begin
        victim = '0;
        for (int i = 0; i < lpr_pkg::FRAMES; i++)
        begin
            if (match_reg[i])
            begin
                victim = victim | lpr_pkg::FRAME_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg     <= match_next;
        look_rank_reg <= look_rank_next;
    end

    assign look_rank = look_rank_reg;
endmodule

/* src/lpr_datapath.sv */
// Datapath: page table and frame table memories, recency ranks, counters,
// configuration register and result register. Uses lpr_pkg, lpr_ram, lpr_rank, lpr_rsp_if.
module lpr_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpr_pkg::cmd_t                cmd,
    output lpr_pkg::sts_t                sts,
    input  logic [lpr_pkg::ADDR_W-1:0]   byte_address,
    input  logic [lpr_pkg::SIZE_W-1:0]   element_size,
    input  logic                         cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]    cfg_wdata,
    lpr_rsp_if.source                    rsp
);
    logic [lpr_pkg::CFG_W-1:0]   fiu_reg;
    logic [lpr_pkg::FILL_W-1:0]  filled_reg;
    logic [lpr_pkg::CNT_W-1:0]   acc_cnt_reg;
    logic [lpr_pkg::CNT_W-1:0]   flt_cnt_reg;
    logic [lpr_pkg::MAP_AW-1:0]  clr_cnt_reg;
    logic                        two_reg;
    logic                        second_reg;
    logic                        out_valid_reg;

    logic [lpr_pkg::PAGE_W-1:0]  page_reg;
    logic [lpr_pkg::PAGE_W-1:0]  p1_reg;
    logic                        fault_reg;
    logic                        evv_reg;
    logic [lpr_pkg::MAP_AW-1:0]  evp_reg;
    logic [lpr_pkg::FRAME_W-1:0] frame_reg;

    logic [lpr_pkg::SIZE_W-1:0]  size_eff;
    logic [lpr_pkg::ADDR_W:0]    last_byte;
    logic [lpr_pkg::PAGE_W-1:0]  p0;
    logic [lpr_pkg::PAGE_W-1:0]  p1;
    logic [lpr_pkg::FILL_W-1:0]  limit;
    logic                        oor;
    logic                        last;

    logic                        map_we;
    logic [lpr_pkg::MAP_AW-1:0]  map_waddr;
    logic [lpr_pkg::MAP_W-1:0]   map_wdata;
    logic [lpr_pkg::MAP_W-1:0]   map_rdata;
    logic                        fp_we;
    logic [lpr_pkg::FRAME_W-1:0] fp_waddr;
    logic [lpr_pkg::MAP_AW-1:0]  fp_rdata;

    logic                        rk_upd;
    logic [lpr_pkg::FRAME_W-1:0] rk_sel;
    logic [lpr_pkg::FRAME_W-1:0] rk_r;
    logic [lpr_pkg::FRAME_W-1:0] look_rank;
    logic [lpr_pkg::FRAME_W-1:0] victim;

    // Page span of the access; a zero size counts as one byte.
    assign size_eff  = (element_size == '0) ? lpr_pkg::SIZE_W'(1) : element_size;
    assign last_byte = {1'b0, byte_address} + (lpr_pkg::ADDR_W + 1)'(size_eff)
                       - (lpr_pkg::ADDR_W + 1)'(1);
    assign p0 = lpr_pkg::PAGE_W'(byte_address[lpr_pkg::ADDR_W-1:lpr_pkg::OFF_W]);
    assign p1 = lpr_pkg::PAGE_W'(last_byte[lpr_pkg::ADDR_W:lpr_pkg::OFF_W]);

    always_comb
    begin
        if (fiu_reg == '0)
        begin
            limit = lpr_pkg::FILL_W'(1);
        end
        else if (int'(fiu_reg) > lpr_pkg::FRAMES)
        begin
            limit = lpr_pkg::FILL_W'(lpr_pkg::FRAMES);
        end
        else
        begin
            limit = lpr_pkg::FILL_W'(fiu_reg);
        end
    end

    assign oor  = page_reg >= lpr_pkg::PAGE_W'(lpr_pkg::NUM_PAGES);
    assign last = !two_reg || second_reg;

    assign sts.clear_last = clr_cnt_reg == lpr_pkg::MAP_AW'(lpr_pkg::NUM_PAGES - 1);
    assign sts.oor        = oor;
    assign sts.hit        = map_rdata[lpr_pkg::FRAME_W];
    assign sts.room       = filled_reg < limit;
    assign sts.last       = last;
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    // Page table: valid bit and frame per page.
    assign map_we = cmd.clear || cmd.fill || cmd.evict || cmd.install;

    always_comb
    begin
        if (cmd.clear)
        begin
            map_waddr = clr_cnt_reg;
        end
        else if (cmd.evict)
        begin
            map_waddr = fp_rdata;
        end
        else
        begin
            map_waddr = page_reg[lpr_pkg::MAP_AW-1:0];
        end
    end

    always_comb
    begin
        if (cmd.fill)
        begin
            map_wdata = {1'b1, filled_reg[lpr_pkg::FRAME_W-1:0]};
        end
        else if (cmd.install)
        begin
            map_wdata = {1'b1, frame_reg};
        end
        else
        begin
            map_wdata = '0;
        end
    end

    lpr_ram #(
        .WIDTH (lpr_pkg::MAP_W),
        .DEPTH (lpr_pkg::NUM_PAGES)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (page_reg[lpr_pkg::MAP_AW-1:0]),
        .rdata (map_rdata)
    );

    // Frame table: page held by each frame.
    assign fp_we    = cmd.fill || cmd.evict;
    assign fp_waddr = cmd.fill ? filled_reg[lpr_pkg::FRAME_W-1:0] : frame_reg;

    lpr_ram #(
        .WIDTH (lpr_pkg::MAP_AW),
        .DEPTH (lpr_pkg::FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fp_we),
        .waddr (fp_waddr),
        .wdata (page_reg[lpr_pkg::MAP_AW-1:0]),
        .raddr (victim),
        .rdata (fp_rdata)
    );

    // A fill ages every filled frame; a hit or replacement ages those younger
    // than the frame that becomes newest.
    assign rk_upd = cmd.fill || cmd.hit_upd || cmd.install;
    assign rk_sel = cmd.fill ? filled_reg[lpr_pkg::FRAME_W-1:0] : frame_reg;
    assign rk_r   = cmd.install ? lpr_pkg::FRAME_W'(filled_reg - 1'b1) : look_rank;

    lpr_rank u_rank (
        .clk        (clk),
        .upd        (rk_upd),
        .upd_all    (cmd.fill),
        .upd_sel    (rk_sel),
        .upd_r      (rk_r),
        .filled     (filled_reg),
        .look_frame (map_rdata[lpr_pkg::FRAME_W-1:0]),
        .look_rank  (look_rank),
        .victim     (victim)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg       <= lpr_pkg::CFG_W'(lpr_pkg::FRAMES_RESET);
            filled_reg    <= '0;
            acc_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
            two_reg       <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.fill)
            begin
                filled_reg <= filled_reg + 1'b1;
            end
            if (cmd.fault)
            begin
                flt_cnt_reg <= flt_cnt_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                acc_cnt_reg <= acc_cnt_reg + 1'b1;
                two_reg     <= p1 != p0;
                second_reg  <= 1'b0;
            end
            else if (cmd.next_page)
            begin
                second_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg <= p0;
            p1_reg   <= p1;
        end
        else if (cmd.next_page)
        begin
            page_reg <= p1_reg;
        end

        if (cmd.accept || cmd.next_page)
        begin
            fault_reg <= 1'b0;
            evv_reg   <= 1'b0;
            evp_reg   <= '0;
            frame_reg <= '0;
        end
        else
        begin
            if (cmd.fault)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.take_hit)
            begin
                frame_reg <= map_rdata[lpr_pkg::FRAME_W-1:0];
            end
            else if (cmd.fill)
            begin
                frame_reg <= filled_reg[lpr_pkg::FRAME_W-1:0];
            end
            else if (cmd.victim)
            begin
                frame_reg <= victim;
            end
            if (cmd.evict)
            begin
                evv_reg <= 1'b1;
                evp_reg <= fp_rdata;
            end
        end

        if (cmd.load_out)
        begin
            rsp.page_number    <= page_reg;
            rsp.fault          <= fault_reg;
            rsp.evicted_valid  <= evv_reg;
            rsp.evicted_page   <= lpr_pkg::EVP_W'(evp_reg);
            rsp.frame_index    <= lpr_pkg::OUT_FRM_W'(frame_reg);
            rsp.out_of_range   <= oor;
            rsp.last_of_access <= last;
            rsp.access_total   <= acc_cnt_reg;
            rsp.fault_total    <= flt_cnt_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
endmodule

/* src/lpr_ctrl.sv */
// Controller state machine: sequences the clearing pass and the lookup,
// fill, replacement and result steps of each page. Uses lpr_pkg.
module lpr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          ready,
    input  lpr_pkg::sts_t sts,
    output lpr_pkg::cmd_t cmd
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_LOOKUP  = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_HIT_UPD = 4'd4;
    localparam logic [3:0] S_VICTIM  = 4'd5;
    localparam logic [3:0] S_EVICT   = 4'd6;
    localparam logic [3:0] S_INSTALL = 4'd7;
    localparam logic [3:0] S_RESULT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // The page table read is under way; a page beyond the table
                // needs no lookup.
                if (sts.oor)
                begin
                    cmd.fault  = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_HIT_UPD;
                end
                else
                begin
                    cmd.fault = 1'b1;
                    if (sts.room)
                    begin
                        cmd.fill   = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_VICTIM;
                    end
                end
            end
            S_HIT_UPD:
            begin
                cmd.hit_upd = 1'b1;
                state_next  = S_RESULT;
            end
            S_VICTIM:
            begin
                cmd.victim = 1'b1;
                state_next = S_EVICT;
            end
            S_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = S_INSTALL;
            end
            S_INSTALL:
            begin
                cmd.install = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_page = 1'b1;
                        state_next    = S_LOOKUP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

/* src/lru_page_replacement.sv */
// LRU page replacement, top level. Uses lpr_pkg, lpr_req_if, lpr_rsp_if, lpr_ctrl, lpr_datapath.
// Per page the controller goes from lookup straight to result when out of range, through decide
// on a fill, decide and hit update on a hit, and decide, victim, evict and install on a replacement;
// the result waits while the result register is still full, and a second page follows directly.
// After reset the page table is cleared one entry a cycle, all 8192 entries, with ready low;
// configuration writes are taken throughout.
`include "assert_macros.svh"

module lru_page_replacement (
    input  logic                       clk,
    input  logic                       rst_n,
    lpr_req_if.sink                    req,
    lpr_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]  cfg_wdata
);
    lpr_pkg::cmd_t cmd;
    lpr_pkg::sts_t sts;
    logic          ready;

    assign req.ready = ready;

    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .ready    (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .byte_address (req.byte_address),
        .element_size (req.element_size),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .rsp          (rsp)
    );

    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.load_out, !rsp.valid || rsp.ready, "result register overwritten")
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "request taken while busy")
    `ASSERT_IMPLIES(a_fill_room, clk, rst_n, cmd.fill, sts.room && !sts.hit, "fill without a free frame")
    `ASSERT_NEXT(a_evict_install, clk, rst_n, cmd.evict, cmd.install, "eviction not followed by install")
endmodule

/* tb/tb_lru_page_replacement.sv */
// Self-checking testbench for the LRU page replacement block.
// Depends on lpr_pkg, lpr_req_if, lpr_rsp_if and the lru_page_replacement RTL;
// it predicts every page result and checks it against the result channel.
module tb_lru_page_replacement;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        logic [lpr_pkg::ADDR_W-1:0] addr;
        logic [lpr_pkg::SIZE_W-1:0] size;
    } access_t;

    typedef struct packed {
        logic [lpr_pkg::PAGE_W-1:0]    page_number;
        logic                          fault;
        logic                          evicted_valid;
        logic [lpr_pkg::EVP_W-1:0]     evicted_page;
        logic [lpr_pkg::OUT_FRM_W-1:0] frame_index;
        logic                          out_of_range;
        logic                          last_of_access;
        logic [lpr_pkg::CNT_W-1:0]     access_total;
        logic [lpr_pkg::CNT_W-1:0]     fault_total;
    } page_result_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lpr_pkg::CFG_W-1:0] cfg_wdata;

    lpr_req_if req_ch();
    lpr_rsp_if rsp_ch();

    lru_page_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the replacement state.
    bit                        page_resident [lpr_pkg::NUM_PAGES];
    int unsigned               page_frame    [lpr_pkg::NUM_PAGES];
    int unsigned               frame_owner   [lpr_pkg::FRAMES];
    int unsigned               frame_age     [lpr_pkg::FRAMES];
    int unsigned               frames_used;
    logic [lpr_pkg::CNT_W-1:0] access_count;
    logic [lpr_pkg::CNT_W-1:0] fault_count;
    logic [lpr_pkg::CFG_W-1:0] frame_limit;

    access_t      pending_accesses [$];
    page_result_t expected_pages   [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned accesses_issued;
    int unsigned accesses_taken;
    int unsigned results_checked;
    int unsigned faults_seen;
    int unsigned evictions_seen;
    int unsigned out_of_range_seen;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    always #6 clk = ~clk;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Moves a frame to the front of the recency order.
    task automatic make_recent(int unsigned frame);
        int unsigned rank;
        rank = frame_age[frame];
        for (int i = 0; i < frames_used; i++)
            if (frame_age[i] < rank)
                frame_age[i]++;
        frame_age[frame] = 0;
    endtask

    task automatic lru_touch(int unsigned page, bit is_last);
        page_result_t r;
        int unsigned  limit;
        int unsigned  victim;
        int unsigned  old_page;
        r = '0;
        r.page_number    = lpr_pkg::PAGE_W'(page);
        r.last_of_access = is_last;
        limit = (frame_limit == 0) ? 1 : frame_limit;
        if (limit > lpr_pkg::FRAMES)
            limit = lpr_pkg::FRAMES;
        if (page >= lpr_pkg::NUM_PAGES)
        begin
            r.fault        = 1'b1;
            r.out_of_range = 1'b1;
            fault_count++;
        end
        else if (page_resident[page])
        begin
            r.frame_index = lpr_pkg::OUT_FRM_W'(page_frame[page]);
            make_recent(page_frame[page]);
        end
        else
        begin
            r.fault = 1'b1;
            fault_count++;
            if (frames_used < limit)
            begin
                for (int i = 0; i < frames_used; i++)
                    frame_age[i]++;
                frame_age[frames_used]   = 0;
                frame_owner[frames_used] = page;
                page_resident[page]      = 1'b1;
                page_frame[page]         = frames_used;
                r.frame_index            = lpr_pkg::OUT_FRM_W'(frames_used);
                frames_used++;
            end
            else
            begin
                // Frames are never released, even when the limit has been lowered.
                victim = 0;
                for (int i = 1; i < frames_used; i++)
                    if (frame_age[i] > frame_age[victim])
                        victim = i;
                old_page = frame_owner[victim];
                page_resident[old_page] = 1'b0;
                r.evicted_valid = 1'b1;
                r.evicted_page  = lpr_pkg::EVP_W'(old_page);
                frame_owner[victim] = page;
                page_resident[page] = 1'b1;
                page_frame[page]    = victim;
                make_recent(victim);
                r.frame_index = lpr_pkg::OUT_FRM_W'(victim);
            end
        end
        r.access_total = access_count;
        r.fault_total  = fault_count;
        expected_pages.push_back(r);
    endtask

    task automatic lru_access(logic [lpr_pkg::ADDR_W-1:0] addr,
                              logic [lpr_pkg::SIZE_W-1:0] size);
        int unsigned bytes;
        int unsigned first_page;
        int unsigned final_page;
        bytes = (size == 0) ? 1 : size;
        access_count++;
        first_page = addr / lpr_pkg::PAGE_BYTES;
        final_page = (addr + bytes - 1) / lpr_pkg::PAGE_BYTES;
        for (int unsigned p = first_page; p <= final_page; p++)
            lru_touch(p, p == final_page);
    endtask

    function automatic access_t make_access(int unsigned addr, int unsigned size);
        access_t a;
        a.addr = lpr_pkg::ADDR_W'(addr);
        a.size = lpr_pkg::SIZE_W'(size);
        return a;
    endfunction

    // Mostly a small working set around a base page so that hits and
    // replacements both occur; the rest spans the whole address space.
    function automatic access_t random_access(int unsigned base, int unsigned span);
        int unsigned pick;
        int unsigned page;
        int unsigned offset;
        pick = $urandom_range(1, 100);
        page = base + $urandom_range(0, span);
        offset = $urandom_range(0, lpr_pkg::PAGE_BYTES - 1);
        if (pick > 60 && pick <= 75)
            offset = lpr_pkg::PAGE_BYTES - $urandom_range(1, 15);
        else if (pick > 75 && pick <= 95)
            page = $urandom_range(0, lpr_pkg::NUM_PAGES - 1);
        else if (pick > 95)
        begin
            page = lpr_pkg::NUM_PAGES - 1;
            offset = lpr_pkg::PAGE_BYTES - $urandom_range(1, 15);
        end
        return make_access(page * lpr_pkg::PAGE_BYTES + offset, $urandom_range(0, 15));
    endfunction

    task automatic wait_for_drain();
        while (pending_accesses.size() != 0 || accesses_issued != accesses_taken ||
               expected_pages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_limit(logic [lpr_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= value;
        frame_limit = value;
        settings_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 26 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 26 : 0;
    endtask

    task automatic run_phase(logic [lpr_pkg::CFG_W-1:0] limit_value, int unsigned count,
                             idle_mode_t mode);
        int unsigned active;
        int unsigned span;
        int unsigned base;
        wait_for_drain();
        write_frame_limit(limit_value);
        set_idling(mode);
        active = (limit_value == 0) ? 1 :
                 (limit_value > lpr_pkg::FRAMES) ? lpr_pkg::FRAMES : limit_value;
        span = active + active / 2 + 1;
        base = $urandom_range(0, lpr_pkg::NUM_PAGES - 1 - span);
        for (int i = 0; i < count; i++)
        begin
            // Halfway through, hold back until every result is in.
            if (i == count / 2)
                wait_for_drain();
            pending_accesses.push_back(random_access(base, span));
        end
    endtask

    // Request driver: holds each request until it is taken.
    always @(posedge clk)
    begin : access_driver
        access_t next_item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                lru_access(req_ch.byte_address, req_ch.element_size);
                accesses_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    next_item = pending_accesses.pop_front();
                    accesses_issued++;
                    req_ch.valid        <= 1'b1;
                    req_ch.byte_address <= next_item.addr;
                    req_ch.element_size <= next_item.size;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        page_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                if (expected_pages.size() == 0)
                    report_mismatch("result with nothing expected", rsp_ch.page_number, 0);
                else
                begin
                    want = expected_pages.pop_front();
                    check_field("page_number", rsp_ch.page_number, want.page_number);
                    check_field("fault", rsp_ch.fault, want.fault);
                    check_field("evicted_valid", rsp_ch.evicted_valid, want.evicted_valid);
                    check_field("evicted_page", rsp_ch.evicted_page, want.evicted_page);
                    check_field("frame_index", rsp_ch.frame_index, want.frame_index);
                    check_field("out_of_range", rsp_ch.out_of_range, want.out_of_range);
                    check_field("last_of_access", rsp_ch.last_of_access, want.last_of_access);
                    check_field("access_total", rsp_ch.access_total, want.access_total);
                    check_field("fault_total", rsp_ch.fault_total, want.fault_total);
                    faults_seen       += want.fault;
                    evictions_seen    += want.evicted_valid;
                    out_of_range_seen += want.out_of_range;
                end
            end
            rsp_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    // The page table clear after reset keeps the channel quiet, which the
    // limit allows for.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.byte_address = '0;
        req_ch.element_size = '0;
        rsp_ch.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        accesses_issued     = 0;
        accesses_taken      = 0;
        results_checked     = 0;
        faults_seen         = 0;
        evictions_seen      = 0;
        out_of_range_seen   = 0;
        settings_used       = 0;
        mismatches          = 0;
        quiet_cycles        = 0;
        frames_used         = 0;
        access_count        = '0;
        fault_count         = '0;
        frame_limit         = lpr_pkg::CFG_W'(lpr_pkg::FRAMES_RESET);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with two frames, so that replacement shows up early.
        write_frame_limit(2);
        set_idling(IDLE_NONE);
        pending_accesses.push_back(make_access(0, 1));
        pending_accesses.push_back(make_access('h10, 0));
        pending_accesses.push_back(make_access(lpr_pkg::PAGE_BYTES, 4));
        pending_accesses.push_back(make_access(lpr_pkg::PAGE_BYTES - 6, 15));
        pending_accesses.push_back(make_access(2 * lpr_pkg::PAGE_BYTES, 8));
        pending_accesses.push_back(make_access('h1FFFFFF, 1));
        pending_accesses.push_back(make_access('h1FFFFFF, 15));
        pending_accesses.push_back(make_access('h1FFFFF8, 8));
        pending_accesses.push_back(make_access('h1FFFFF9, 8));
        pending_accesses.push_back(make_access('h1000000, 15));
        pending_accesses.push_back(make_access('h0AAAAAA, 5));
        pending_accesses.push_back(make_access('h1555555, 10));
        pending_accesses.push_back(make_access(lpr_pkg::PAGE_BYTES - 1, 2));
        pending_accesses.push_back(make_access(0, 8));
        pending_accesses.push_back(make_access(3 * lpr_pkg::PAGE_BYTES, 1));
        pending_accesses.push_back(make_access(lpr_pkg::PAGE_BYTES, 0));
        pending_accesses.push_back(make_access('h0FFFFFF, 7));
        pending_accesses.push_back(make_access(2 * lpr_pkg::PAGE_BYTES - 1, 15));

        // Small limits come first while frames can still be filled; the zero
        // and one settings leave the already filled frames in place.
        run_phase(0, 200, IDLE_SENDER);
        run_phase(5, 200, IDLE_RECEIVER);
        run_phase(1, 200, IDLE_BOTH);
        run_phase(lpr_pkg::CFG_W'($urandom_range(6, 40)), 210, IDLE_NONE);
        run_phase(127, 210, IDLE_SENDER);
        run_phase(64, 210, IDLE_RECEIVER);
        run_phase(lpr_pkg::CFG_W'($urandom_range(1, 64)), 200, IDLE_BOTH);
        wait_for_drain();

        $display("Covered %0d accesses and %0d page results over %0d frame limit settings,",
                 accesses_taken, results_checked, settings_used);
        $display("with %0d faults, %0d replacements and %0d pages beyond the table.",
                 faults_seen, evictions_seen, out_of_range_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lpr_pkg.sv
src/lpr_req_if.sv
src/lpr_rsp_if.sv
src/lpr_ram.sv
src/lpr_rank.sv
src/lpr_datapath.sv
src/lpr_ctrl.sv
src/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
